// ===== hw/rtl/planar_velocity_integrator_assert.svh =====
// ----------------------------------------------------------------------------
// Planar velocity integrator assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PLANAR_VELOCITY_INTEGRATOR_ASSERT_SVH
`define PLANAR_VELOCITY_INTEGRATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define PVI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PVI_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PVI_ASSERT(lbl, prop, msg)
`define PVI_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hw/rtl/pvi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvi_pkg
// Shared constants, datapath commands and status for the velocity integrator.
// ----------------------------------------------------------------------------
package pvi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 16;
    localparam int VAL_W     = 32;
    localparam int FACT_W    = DT_W + 1;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [VAL_W-1:0] ACCEL_RST    = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] FRICTION_RST = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] LIMIT_RST    = VAL_W'(100) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL       = 2'd0,
        REG_FRICTION    = 2'd1,
        REG_SPEED_LIMIT = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ACC_MUL,
        OP_ACC_ADD,
        OP_FRIC_MUL,
        OP_FRIC_FACT,
        OP_DAMP_X,
        OP_DAMP_Y,
        OP_DAMP_END,
        OP_SQ_X,
        OP_SQ_Y,
        OP_LIM,
        OP_ROOT_START,
        OP_ROOT_TAKE,
        OP_DIVX_MUL,
        OP_DIV_START,
        OP_DIVX_TAKE,
        OP_DIVY_MUL,
        OP_DIVY_TAKE,
        OP_POS_X,
        OP_POS_Y,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        logic over_limit;
        logic fric_en;
        logic iter_busy;
        logic out_busy;
    } dp_status_t;

    typedef enum logic {
        ITER_SQRT = 1'b0,
        ITER_DIV  = 1'b1
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_cmd_t;

endpackage

// ===== hw/rtl/planar_velocity_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_velocity_integrator
// Euler velocity/position integrator with friction and speed clamp, Q16.16.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_*       in   press_up/down/left/right, step_time
// m_*       out  pos_x, pos_y, vel_x, vel_y
// cfg_*     in   register index, 32-bit write data
//
// One step at a time; the speed clamp adds a square root and two divides, all
// run in the shared iterative unit.
// Result is held in the output register; a new step is taken meanwhile, but
// its commit waits until m_tready drains the previous result.
// Reset clears motion state and loads register defaults; cfg writes always ready.
// ----------------------------------------------------------------------------
module planar_velocity_integrator
    import pvi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // press_up, press_down, press_left, press_right, step_time[15:0], pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [127:0]         m_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    op_t              op;
    dp_status_t       sts;
    logic [VAL_W-1:0] pos_x;
    logic [VAL_W-1:0] pos_y;
    logic [VAL_W-1:0] vel_x;
    logic [VAL_W-1:0] vel_y;

    assign cfg_ready = 1'b1;

    pvi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .op       (op)
    );

    pvi_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_press  (s_tdata[3:0]),
        .in_dt     (s_tdata[4 +: DT_W]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .sts       (sts)
    );

    assign m_tdata = {vel_y, vel_x, pos_y, pos_x};

endmodule

// ===== hw/rtl/pvi_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvi_iter
// Shared radix-2 unit: 64-bit integer square root or 64/32 divide, one
// result bit per cycle.
// ----------------------------------------------------------------------------
module pvi_iter
    import pvi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  iter_cmd_t         cmd,
    input  logic [PROD_W-1:0] operand,
    input  logic [VAL_W-1:0]  divisor,
    output logic              busy,
    output logic [VAL_W-1:0]  result
);

    logic              busy_reg;
    iter_mode_t        mode_reg;
    logic [4:0]        cnt_reg;
    logic [VAL_W+1:0]  acc_reg;
    logic [PROD_W-1:0] work_reg;
    logic [VAL_W-1:0]  res_reg;

    logic [VAL_W+1:0]  part;
    logic [VAL_W+1:0]  trial;
    logic              ge;
    logic [VAL_W+1:0]  acc_next;
    logic [PROD_W-1:0] work_next;

    always_comb
    begin
        if (mode_reg == ITER_SQRT)
        begin
            part      = {acc_reg[VAL_W-1:0], work_reg[PROD_W-1 -: 2]};
            trial     = {res_reg, 2'b01};
            work_next = {work_reg[PROD_W-3:0], 2'b00};
        end
        else
        begin
            part      = {1'b0, acc_reg[VAL_W-1:0], work_reg[PROD_W-1]};
            trial     = {2'b00, divisor};
            work_next = {work_reg[PROD_W-2:0], 1'b0};
        end
        ge       = (part >= trial);
        acc_next = ge ? (part - trial) : part;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= ITER_SQRT;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            mode_reg <= cmd.mode;
            cnt_reg  <= 5'd31;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            res_reg <= '0;
            if (cmd.mode == ITER_SQRT)
            begin
                acc_reg  <= '0;
                work_reg <= operand;
            end
            else
            begin
                acc_reg  <= {2'b00, operand[PROD_W-1:VAL_W]};
                work_reg <= {operand[VAL_W-1:0], {VAL_W{1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            work_reg <= work_next;
            res_reg  <= {res_reg[VAL_W-2:0], ge};
        end
    end

    assign busy   = busy_reg;
    assign result = res_reg;

endmodule

// ===== hw/rtl/pvi_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvi_dpath
// Datapath: config registers, motion state, one shared 32x32 multiplier,
// saturating adders and the root/divide unit, all driven by op.
// ----------------------------------------------------------------------------
module pvi_dpath
    import pvi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  op_t                  op,
    input  logic [3:0]           in_press,
    input  logic [DT_W-1:0]      in_dt,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [VAL_W-1:0]     pos_x,
    output logic [VAL_W-1:0]     pos_y,
    output logic [VAL_W-1:0]     vel_x,
    output logic [VAL_W-1:0]     vel_y,
    output dp_status_t           sts
);

    localparam logic [PROD_W-1:0] ONE_FACT = PROD_W'(1) << (FRAC_BITS + DT_W);

    logic [VAL_W-1:0]  accel_reg;
    logic [VAL_W-1:0]  fric_reg;
    logic [VAL_W-1:0]  limit_reg;
    logic [3:0]        press_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [VAL_W-1:0]  vx_reg;
    logic [VAL_W-1:0]  vy_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] sum_reg;
    logic [FACT_W-1:0] factor_reg;
    logic [VAL_W-1:0]  sp_reg;
    logic [VAL_W-1:0]  pnx_reg;
    logic [VAL_W-1:0]  pos_x_reg;
    logic [VAL_W-1:0]  pos_y_reg;
    logic [VAL_W-1:0]  vel_x_reg;
    logic [VAL_W-1:0]  vel_y_reg;
    logic              out_valid_reg;

    logic [VAL_W-1:0]  mag_x;
    logic [VAL_W-1:0]  mag_y;
    logic [VAL_W-1:0]  mul_a;
    logic [VAL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              mul_en;
    logic [VAL_W-1:0]  step;
    logic [PROD_W-1:0] fact_diff;
    logic              x_move;
    logic              y_move;
    iter_cmd_t         iter_cmd;
    logic              iter_busy;
    logic [VAL_W-1:0]  iter_res;

    function automatic logic [VAL_W-1:0] add_sat(
        input logic [VAL_W-1:0] base,
        input logic [VAL_W-1:0] mag,
        input logic             neg
    );
        logic signed [VAL_W+1:0] b;
        logic signed [VAL_W+1:0] m;
        logic signed [VAL_W+1:0] s;
        b = {{2{base[VAL_W-1]}}, base};
        m = {2'b00, mag};
        s = neg ? (b - m) : (b + m);
        if (s > $signed({3'b000, {(VAL_W-1){1'b1}}}))
        begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (s < $signed({3'b111, {(VAL_W-1){1'b0}}}))
        begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end
        return s[VAL_W-1:0];
    endfunction

    assign mag_x  = vx_reg[VAL_W-1] ? (~vx_reg + VAL_W'(1)) : vx_reg;
    assign mag_y  = vy_reg[VAL_W-1] ? (~vy_reg + VAL_W'(1)) : vy_reg;
    assign step   = prod_reg[DT_W +: VAL_W];
    assign x_move = press_reg[3] ^ press_reg[2];
    assign y_move = press_reg[1] ^ press_reg[0];
    assign fact_diff = ONE_FACT - prod_reg;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (op)
            OP_ACC_MUL:
            begin
                mul_a = accel_reg;
                mul_b = VAL_W'(dt_reg);
            end
            OP_FRIC_MUL:
            begin
                mul_a = fric_reg;
                mul_b = VAL_W'(dt_reg);
            end
            OP_DAMP_X:
            begin
                mul_a = mag_x;
                mul_b = VAL_W'(factor_reg);
            end
            OP_DAMP_Y:
            begin
                mul_a = mag_y;
                mul_b = VAL_W'(factor_reg);
            end
            OP_SQ_X:
            begin
                mul_a = mag_x;
                mul_b = mag_x;
            end
            OP_SQ_Y:
            begin
                mul_a = mag_y;
                mul_b = mag_y;
            end
            OP_LIM:
            begin
                mul_a = limit_reg;
                mul_b = limit_reg;
            end
            OP_DIVX_MUL:
            begin
                mul_a = mag_x;
                mul_b = limit_reg;
            end
            OP_DIVY_MUL:
            begin
                mul_a = mag_y;
                mul_b = limit_reg;
            end
            OP_POS_X:
            begin
                mul_a = mag_x;
                mul_b = VAL_W'(dt_reg);
            end
            OP_POS_Y:
            begin
                mul_a = mag_y;
                mul_b = VAL_W'(dt_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign iter_cmd.start = (op == OP_ROOT_START) || (op == OP_DIV_START);
    assign iter_cmd.mode  = (op == OP_DIV_START) ? ITER_DIV : ITER_SQRT;

    pvi_iter u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (iter_cmd),
        .operand ((op == OP_DIV_START) ? prod_reg : sum_reg),
        .divisor (sp_reg),
        .busy    (iter_busy),
        .result  (iter_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg     <= ACCEL_RST;
            fric_reg      <= FRICTION_RST;
            limit_reg     <= LIMIT_RST;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ACCEL)
                begin
                    accel_reg <= cfg_data;
                end
                if (cfg_index == REG_FRICTION)
                begin
                    fric_reg <= cfg_data;
                end
                if (cfg_index == REG_SPEED_LIMIT)
                begin
                    limit_reg <= cfg_data;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (op == OP_COMMIT)
            begin
                pos_x_reg     <= pnx_reg;
                pos_y_reg     <= add_sat(pos_y_reg, step, vy_reg[VAL_W-1]);
                vel_x_reg     <= vx_reg;
                vel_y_reg     <= vy_reg;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
        case (op)
            OP_LOAD:
            begin
                press_reg <= in_press;
                dt_reg    <= in_dt;
            end
            OP_ACC_ADD:
            begin
                vx_reg <= add_sat(vel_x_reg, x_move ? step : '0, press_reg[2]);
                vy_reg <= add_sat(vel_y_reg, y_move ? step : '0, press_reg[0]);
            end
            OP_FRIC_FACT:
            begin
                factor_reg <= (prod_reg < ONE_FACT) ? FACT_W'(fact_diff >> FRAC_BITS) : '0;
            end
            OP_DAMP_Y:
            begin
                vx_reg <= add_sat('0, step, vx_reg[VAL_W-1]);
            end
            OP_DAMP_END:
            begin
                vy_reg <= add_sat('0, step, vy_reg[VAL_W-1]);
            end
            OP_SQ_Y:
            begin
                sum_reg <= prod_reg;
            end
            OP_LIM:
            begin
                sum_reg <= sum_reg + prod_reg;
            end
            OP_ROOT_TAKE:
            begin
                sp_reg <= (iter_res == '0) ? VAL_W'(1) : iter_res;
            end
            OP_DIVX_TAKE:
            begin
                vx_reg <= add_sat('0, iter_res, vx_reg[VAL_W-1]);
            end
            OP_DIVY_TAKE:
            begin
                vy_reg <= add_sat('0, iter_res, vy_reg[VAL_W-1]);
            end
            OP_POS_Y:
            begin
                pnx_reg <= add_sat(pos_x_reg, step, vx_reg[VAL_W-1]);
            end
            default:
            begin
            end
        endcase
    end

    assign sts.over_limit = (sum_reg > prod_reg);
    assign sts.fric_en    = (accel_reg == '0) || (!x_move && !y_move);
    assign sts.iter_busy  = iter_busy;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;

endmodule

// ===== hw/rtl/pvi_ctrl.sv =====
`timescale 1ns / 1ps
`include "planar_velocity_integrator_assert.svh"
// ----------------------------------------------------------------------------
// pvi_ctrl
// Step sequencer: one step through datapath, one op a cycle; waits on busy.
// ----------------------------------------------------------------------------
module pvi_ctrl
    import pvi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t sts,
    output op_t        op
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC_MUL,
        S_ACC_ADD,
        S_FRIC_MUL,
        S_FRIC_FACT,
        S_DAMP_X,
        S_DAMP_Y,
        S_DAMP_END,
        S_SQ_X,
        S_SQ_Y,
        S_LIM,
        S_CMP,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DIVX_MUL,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_MUL,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_POS_X,
        S_POS_Y,
        S_COMMIT
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:      if (in_valid) state_reg <= S_ACC_MUL;
                S_ACC_MUL:   state_reg <= S_ACC_ADD;
                S_ACC_ADD:   state_reg <= sts.fric_en ? S_FRIC_MUL : S_SQ_X;
                S_FRIC_MUL:  state_reg <= S_FRIC_FACT;
                S_FRIC_FACT: state_reg <= S_DAMP_X;
                S_DAMP_X:    state_reg <= S_DAMP_Y;
                S_DAMP_Y:    state_reg <= S_DAMP_END;
                S_DAMP_END:  state_reg <= S_SQ_X;
                S_SQ_X:      state_reg <= S_SQ_Y;
                S_SQ_Y:      state_reg <= S_LIM;
                S_LIM:       state_reg <= S_CMP;
                S_CMP:       state_reg <= sts.over_limit ? S_ROOT_GO : S_POS_X;
                S_ROOT_GO:   state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT: if (!sts.iter_busy) state_reg <= S_DIVX_MUL;
                S_DIVX_MUL:  state_reg <= S_DIVX_GO;
                S_DIVX_GO:   state_reg <= S_DIVX_WAIT;
                S_DIVX_WAIT: if (!sts.iter_busy) state_reg <= S_DIVY_MUL;
                S_DIVY_MUL:  state_reg <= S_DIVY_GO;
                S_DIVY_GO:   state_reg <= S_DIVY_WAIT;
                S_DIVY_WAIT: if (!sts.iter_busy) state_reg <= S_POS_X;
                S_POS_X:     state_reg <= S_POS_Y;
                S_POS_Y:     state_reg <= S_COMMIT;
                S_COMMIT:    if (!sts.out_busy) state_reg <= S_IDLE;
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:      op = in_valid ? OP_LOAD : OP_NOP;
            S_ACC_MUL:   op = OP_ACC_MUL;
            S_ACC_ADD:   op = OP_ACC_ADD;
            S_FRIC_MUL:  op = OP_FRIC_MUL;
            S_FRIC_FACT: op = OP_FRIC_FACT;
            S_DAMP_X:    op = OP_DAMP_X;
            S_DAMP_Y:    op = OP_DAMP_Y;
            S_DAMP_END:  op = OP_DAMP_END;
            S_SQ_X:      op = OP_SQ_X;
            S_SQ_Y:      op = OP_SQ_Y;
            S_LIM:       op = OP_LIM;
            S_ROOT_GO:   op = OP_ROOT_START;
            S_ROOT_WAIT: op = sts.iter_busy ? OP_NOP : OP_ROOT_TAKE;
            S_DIVX_MUL:  op = OP_DIVX_MUL;
            S_DIVX_GO:   op = OP_DIV_START;
            S_DIVX_WAIT: op = sts.iter_busy ? OP_NOP : OP_DIVX_TAKE;
            S_DIVY_MUL:  op = OP_DIVY_MUL;
            S_DIVY_GO:   op = OP_DIV_START;
            S_DIVY_WAIT: op = sts.iter_busy ? OP_NOP : OP_DIVY_TAKE;
            S_POS_X:     op = OP_POS_X;
            S_POS_Y:     op = OP_POS_Y;
            S_COMMIT:    op = sts.out_busy ? OP_NOP : OP_COMMIT;
            default:     op = OP_NOP;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    `PVI_ASSERT(a_commit_free, (op == OP_COMMIT) |-> !sts.out_busy, "commit over held result")
    `PVI_ASSERT_NEVER(a_idle_iter, (state_reg == S_IDLE) && sts.iter_busy, "iter busy in idle")
    `PVI_ASSERT(a_take_done, (op == OP_ROOT_TAKE || op == OP_DIVX_TAKE || op == OP_DIVY_TAKE) |-> !sts.iter_busy, "iter result taken early")
    `PVI_ASSERT(a_start_busy, (op == OP_ROOT_START || op == OP_DIV_START) |=> sts.iter_busy, "iter did not start")

endmodule
